FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the H-bridge driver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define HB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define HB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HB_ASSERT(lbl, clk, rst_n, prop, msg)
`define HB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/hbpmd_pkg.sv
// ----------------------------------------------------------------------------
// hbpmd_pkg
// Types, widths and constants of the H-bridge PWM motion driver.
// ----------------------------------------------------------------------------
package hbpmd_pkg;

    localparam int DEF_PERIOD_TICKS = 20;
    localparam int DEF_RATE_MAX     = 1000;

    localparam int OP_W      = 2;
    localparam int CNT_W     = 32;
    localparam int RATE_W    = 16;
    localparam int RATE_CL_W = 10;   // clamped rate, at most 1000
    localparam int PROD_W    = 21;   // period ticks times clamped rate, 20000 with the default period and rate limit
    localparam int PHASE_W   = 12;
    localparam int HT_W      = 12;
    localparam int FRAC_W    = 10;
    localparam int ACC_W     = 11;
    localparam int BUDGET_W  = 48;
    localparam int POS_W     = 32;
    localparam int DIST_W    = 33;

    localparam int THOUSAND  = 1000;

    // Division by 1000 as a multiplication by ceil(2^32 / 1000), exact below 2^21.
    localparam int DIV_SHIFT = 32;
    localparam int MAGIC_W   = 23;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = 23'd4294968;
    localparam int DIVP_W    = PROD_W + MAGIC_W;

    localparam logic [1:0] PIN_FWD = 2'b01;
    localparam logic [1:0] PIN_REV = 2'b10;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_GOTO = 2'd2,
        OP_STOP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_PAUSED = 2'd0,
        MODE_FWD    = 2'd1,
        MODE_REV    = 2'd2
    } t_run_mode;

    // Command word after the input stage, with its state-independent products.
    typedef struct packed {
        t_op                       op;
        logic signed [CNT_W-1:0]   cnt;
        logic [PROD_W-1:0]         prod;
        logic signed [BUDGET_W-1:0] stop_budget;
    } t_stage;

endpackage

FILE: rtl/hbpmd_if.sv
// ----------------------------------------------------------------------------
// hbpmd_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface hbpmd_cmd_if;
    import hbpmd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [CNT_W-1:0] step_count;
    logic [RATE_W-1:0]       rate;

    modport source (output valid, output op, output step_count, output rate, input ready);
    modport sink   (input valid, input op, input step_count, input rate, output ready);
endinterface

interface hbpmd_res_if;
    import hbpmd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    fwd_pin;
    logic                    rev_pin;
    logic                    ack;
    logic                    busy_res;
    logic signed [POS_W-1:0] position;

    modport source (output valid, output fwd_pin, output rev_pin, output ack,
                    output busy_res, output position, input ready);
    modport sink   (input valid, input fwd_pin, input rev_pin, input ack,
                    input busy_res, input position, output ready);
endinterface

FILE: rtl/hbridge_pwm_motion_driver_unit.sv
// ----------------------------------------------------------------------------
// hbridge_pwm_motion_driver_unit
// PWM drive of a two-pin H-bridge from tick, move, goto and stop commands.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command word per handshake: tick, relative move, absolute
//   goto or timed stop. o_res returns exactly one result word for each command:
//   the two bridge pin levels, an ack when a command completes, the busy flag
//   and the signed position.
//   The accepting edge loads the input stage, which forms the duty product and
//   the stop wait product; the state update then splits the duty by 1000 and
//   writes the result register once that register is free. Throughput is one
//   word per cycle while the receiver takes every result word, set by the
//   state update loop.
//   After reset the motor is paused, the pins are low, the position is zero and
//   no command is busy.
//   When the receiver stalls, the result register holds its word and the input
//   stage takes one more command; i_cmd.ready then falls until the result word
//   is taken.
// ----------------------------------------------------------------------------
module hbridge_pwm_motion_driver_unit #(
    parameter int PERIOD_TICKS = hbpmd_pkg::DEF_PERIOD_TICKS,
    parameter int RATE_MAX     = hbpmd_pkg::DEF_RATE_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hbpmd_cmd_if.sink   i_cmd,
    hbpmd_res_if.source o_res
);
    import hbpmd_pkg::*;

    logic                       r_s1_valid;
    t_stage                     r_s1;
    logic                       w_take;
    logic                       w_accept;
    logic [RATE_CL_W-1:0]       w_rate_cl;
    logic signed [BUDGET_W-1:0] w_rate_s;
    logic signed [BUDGET_W-1:0] w_cnt_s;

    assign i_cmd.ready = !r_s1_valid || w_take;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_rate_cl = (i_cmd.rate > RATE_W'(RATE_MAX)) ? RATE_CL_W'(RATE_MAX)
                                                       : RATE_CL_W'(i_cmd.rate);
    assign w_rate_s  = BUDGET_W'($signed({1'b0, i_cmd.rate}));
    assign w_cnt_s   = BUDGET_W'(i_cmd.step_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1.op          <= t_op'(i_cmd.op);
            r_s1.cnt         <= i_cmd.step_count;
            r_s1.prod        <= PROD_W'(PERIOD_TICKS) * PROD_W'(w_rate_cl);
            r_s1.stop_budget <= w_rate_s * w_cnt_s;
        end
    end

    hbpmd_core #(
        .PERIOD_TICKS (PERIOD_TICKS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (r_s1_valid),
        .i_s1       (r_s1),
        .o_s1_take  (w_take),
        .o_res      (o_res)
    );

endmodule

FILE: rtl/hbpmd_core.sv
// ----------------------------------------------------------------------------
// hbpmd_core
// Motion state update and result register of the H-bridge driver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbpmd_core #(
    parameter int PERIOD_TICKS = hbpmd_pkg::DEF_PERIOD_TICKS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s1_valid,
    input  hbpmd_pkg::t_stage i_s1,
    output logic              o_s1_take,
    hbpmd_res_if.source       o_res
);
    import hbpmd_pkg::*;

    t_run_mode                  r_mode, n_mode;
    logic [PHASE_W-1:0]         r_phase, n_phase;
    logic                       r_edge, n_edge;
    logic [HT_W-1:0]            r_ht, n_ht;
    logic [FRAC_W-1:0]          r_frac, n_frac;
    logic [ACC_W-1:0]           r_acc, n_acc;
    logic signed [BUDGET_W-1:0] r_budget, n_budget;
    logic [POS_W-1:0]           r_pos, n_pos;
    logic                       r_done, n_done;
    logic [1:0]                 r_pins, n_pins;
    logic                       n_ack;

    logic                       r_out_valid;
    logic                       r_out_fwd, r_out_rev, r_out_ack, r_out_busy;
    logic [POS_W-1:0]           r_out_pos;

    logic                       w_fire;
    logic [DIVP_W-1:0]          w_divp;
    logic [HT_W-1:0]            w_ht;
    logic [PROD_W-1:0]          w_frac_full;

    logic [1:0]                 v_act;
    logic [PHASE_W-1:0]         v_ph;
    logic                       v_ep;
    logic                       v_step;
    logic [ACC_W-1:0]           v_acc_sum;
    logic signed [BUDGET_W-1:0] v_bud_dec;
    logic signed [DIST_W-1:0]   v_diff;
    logic [DIST_W-1:0]          v_dist;
    logic                       v_fwd;

    assign w_fire    = i_s1_valid && (!r_out_valid || o_res.ready);
    assign o_s1_take = w_fire;

    // Duty split: whole high ticks and the remainder in thousandths.
    assign w_divp      = DIVP_W'(i_s1.prod) * DIVP_W'(DIV_MAGIC);
    assign w_ht        = w_divp[DIV_SHIFT +: HT_W];
    assign w_frac_full = i_s1.prod - PROD_W'(w_ht) * PROD_W'(THOUSAND);

    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_edge    = r_edge;
        n_ht      = r_ht;
        n_frac    = r_frac;
        n_acc     = r_acc;
        n_budget  = r_budget;
        n_pos     = r_pos;
        n_done    = r_done;
        n_pins    = r_pins;
        n_ack     = 1'b0;
        v_act     = (r_mode == MODE_FWD) ? PIN_FWD : PIN_REV;
        v_ph      = r_phase;
        v_ep      = r_edge;
        v_step    = 1'b0;
        v_acc_sum = r_acc + ACC_W'(r_frac);
        v_bud_dec = r_budget - BUDGET_W'(1);
        v_diff    = {i_s1.cnt[CNT_W-1], i_s1.cnt};
        v_dist    = '0;
        v_fwd     = 1'b1;

        if (w_fire) begin
            case (i_s1.op)
                OP_TICK: begin
                    if (r_mode != MODE_PAUSED) begin
                        if (v_ph >= PHASE_W'(PERIOD_TICKS)) begin
                            v_ph = v_ph - PHASE_W'(PERIOD_TICKS);
                            v_ep = 1'b1;
                        end
                        if (v_ph < r_ht) begin
                            if (v_ep) begin
                                v_ep   = 1'b0;
                                n_pins = n_pins | v_act;
                            end
                            v_step = 1'b1;
                        end else if (v_ph > r_ht) begin
                            if (v_ep) begin
                                n_pins = n_pins & ~v_act;
                            end
                        end else begin
                            // Boundary tick: the dither decides whether it is driven high.
                            if (v_acc_sum >= ACC_W'(THOUSAND)) begin
                                v_ep   = 1'b1;
                                n_acc  = v_acc_sum - ACC_W'(THOUSAND);
                                n_pins = n_pins | v_act;
                                v_step = 1'b1;
                            end else begin
                                v_ep   = 1'b0;
                                n_acc  = v_acc_sum;
                                n_pins = n_pins & ~v_act;
                            end
                        end
                        n_edge  = v_ep;
                        n_phase = v_ph + PHASE_W'(1);
                        if (v_step) begin
                            n_budget = v_bud_dec;
                            n_pos    = (r_mode == MODE_FWD) ? r_pos + POS_W'(1)
                                                            : r_pos - POS_W'(1);
                            if (v_bud_dec <= BUDGET_W'(1)) begin
                                n_pins = n_pins & ~v_act;
                                n_mode = MODE_PAUSED;
                                n_ack  = 1'b1;
                                n_done = 1'b1;
                            end
                        end
                    end else if (!r_done && r_budget > BUDGET_W'(0)) begin
                        n_budget = v_bud_dec;
                        if (v_bud_dec == BUDGET_W'(0)) begin
                            n_ack  = 1'b1;
                            n_done = 1'b1;
                        end
                    end
                end
                OP_MOVE, OP_GOTO: begin
                    if (i_s1.op == OP_GOTO) begin
                        v_diff = {i_s1.cnt[CNT_W-1], i_s1.cnt} - {r_pos[POS_W-1], r_pos};
                    end
                    v_fwd    = !v_diff[DIST_W-1];
                    v_dist   = v_fwd ? v_diff : -v_diff;
                    n_ht     = w_ht;
                    n_frac   = w_frac_full[FRAC_W-1:0];
                    n_acc    = '0;
                    n_budget = BUDGET_W'(v_dist);
                    n_pins   = v_fwd ? (r_pins & ~PIN_REV) : (r_pins & ~PIN_FWD);
                    if (v_dist == '0) begin
                        n_mode = MODE_PAUSED;
                        n_ack  = 1'b1;
                        n_done = 1'b1;
                    end else begin
                        n_mode = v_fwd ? MODE_FWD : MODE_REV;
                        n_done = 1'b0;
                    end
                end
                OP_STOP: begin
                    n_mode   = MODE_PAUSED;
                    n_budget = i_s1.stop_budget;
                    n_pins   = 2'b00;
                    if (i_s1.cnt[CNT_W-1] || i_s1.cnt == '0 || i_s1.stop_budget == '0) begin
                        n_ack  = 1'b1;
                        n_done = 1'b1;
                    end else begin
                        n_done = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PAUSED;
            r_phase  <= '0;
            r_edge   <= 1'b0;
            r_ht     <= '0;
            r_frac   <= '0;
            r_acc    <= '0;
            r_budget <= '0;
            r_pos    <= '0;
            r_done   <= 1'b1;
            r_pins   <= 2'b00;
        end else begin
            r_mode   <= n_mode;
            r_phase  <= n_phase;
            r_edge   <= n_edge;
            r_ht     <= n_ht;
            r_frac   <= n_frac;
            r_acc    <= n_acc;
            r_budget <= n_budget;
            r_pos    <= n_pos;
            r_done   <= n_done;
            r_pins   <= n_pins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_fwd  <= n_pins[0];
            r_out_rev  <= n_pins[1];
            r_out_ack  <= n_ack;
            r_out_busy <= !n_done;
            r_out_pos  <= n_pos;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.fwd_pin  = r_out_fwd;
    assign o_res.rev_pin  = r_out_rev;
    assign o_res.ack      = r_out_ack;
    assign o_res.busy_res = r_out_busy;
    assign o_res.position = r_out_pos;

    `HB_ASSERT(a_pins_exclusive, i_clk, i_rst_n, !(r_pins[0] && r_pins[1]), "both bridge pins driven")
    `HB_ASSERT(a_run_not_done, i_clk, i_rst_n, (r_mode != MODE_PAUSED) |-> !r_done, "running with command done")
    `HB_ASSERT(a_pos_unit_step, i_clk, i_rst_n, (r_pos != $past(r_pos)) |-> ((r_pos == $past(r_pos) + POS_W'(1)) || (r_pos == $past(r_pos) - POS_W'(1))), "position jumped")
    `HB_ASSERT(a_ack_not_busy, i_clk, i_rst_n, (r_out_valid && r_out_ack) |-> !r_out_busy, "ack with busy set")

endmodule
